[rtl/core/fdd_pkg.sv]
// ----------------------------------------------------------------------------
// fdd_pkg: shared types and stencil tables of the derivative block
// Coefficient tables, denominators, job control word and state encodings.
// ----------------------------------------------------------------------------
package fdd_pkg;

  localparam int COEF_W          = 12;
  localparam int DEN_W           = 10;
  localparam int ACC_GUARD       = 12;
  localparam int DIV_STEPS       = 4;
  localparam int FRAC_BITS       = 16;
  localparam int JOB_QUEUE_DEPTH = 2;

  localparam logic [31:0] INV_STEP_RESET = 32'h0001_0000;
  localparam logic        REG_INV_STEP   = 1'b0;

  // central numerators for one to four points per side, taps one to four
  localparam logic signed [COEF_W-1:0] CEN_NUM [4][4] = '{
    '{1, 0, 0, 0}, '{8, -1, 0, 0}, '{45, -9, 1, 0}, '{672, -168, 32, -3}};
  localparam logic [DEN_W-1:0] CEN_DEN [4] = '{2, 12, 60, 840};

  // one-sided numerators for one to four points, taps zero to four
  localparam logic signed [COEF_W-1:0] ONE_NUM [4][5] = '{
    '{-1, 1, 0, 0, 0}, '{-3, 4, -1, 0, 0}, '{-11, 18, -9, 2, 0},
    '{-25, 48, -36, 16, -3}};
  localparam logic [DEN_W-1:0] ONE_DEN [4] = '{1, 2, 6, 12};

  typedef enum logic [1:0] {F_IDLE, F_SEL, F_MAC, F_PUSH} front_state_e;
  typedef enum logic [2:0] {B_IDLE, B_MUL, B_CHK, B_DIV, B_DONE} back_state_e;

  typedef struct packed {
    logic [DEN_W-1:0] den;
    logic             eor;
  } job_ctrl_t;

  // weight of the tap at offset d from the centre
  function automatic logic signed [COEF_W-1:0] stencil_coef(
    input logic [2:0] nf, input logic [2:0] nb, input logic signed [4:0] d);
    logic signed [COEF_W-1:0] c;
    logic [2:0] ad;
    logic [1:0] row;
    c   = '0;
    ad  = d[4] ? 3'(-d) : 3'(d);
    row = 2'd0;
    if (nf == nb) begin
      row = 2'(nf - 3'd1);
      if (nf != 3'd0 && ad != 3'd0 && ad <= nf) begin
        c = CEN_NUM[row][2'(ad - 3'd1)];
        if (d[4]) c = -c;
      end
    end else if (nf > nb) begin
      row = 2'(nf - 3'd1);
      if (!d[4] && ad <= nf) c = ONE_NUM[row][ad];
    end else begin
      row = 2'(nb - 3'd1);
      if (ad <= nb && (d[4] || ad == 3'd0)) c = -ONE_NUM[row][ad];
    end
    return c;
  endfunction

  function automatic logic [DEN_W-1:0] stencil_den(input logic [2:0] nf, input logic [2:0] nb);
    logic [DEN_W-1:0] dn;
    dn = DEN_W'(1);
    if (nf == nb) begin
      if (nf != 3'd0) dn = CEN_DEN[2'(nf - 3'd1)];
    end else if (nf > nb) begin
      dn = ONE_DEN[2'(nf - 3'd1)];
    end else begin
      dn = ONE_DEN[2'(nb - 3'd1)];
    end
    return dn;
  endfunction

endpackage

[rtl/core/fdd_front.sv]
// ----------------------------------------------------------------------------
// fdd_front: sample window and stencil sequencer
// Shifts samples into the window, picks the stencil for each due result and
// accumulates the stencil sum one tap a cycle, then hands a job to the queue.
// ----------------------------------------------------------------------------
module fdd_front import fdd_pkg::*; #(
  parameter int SIDE_POINTS  = 4,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push_i,
  input  logic signed [SAMPLE_WIDTH-1:0]        sample_i,
  input  logic                                  last_i,
  output logic                                  full_o,
  output logic                                  job_valid_o,
  input  logic                                  job_ready_i,
  output logic signed [SAMPLE_WIDTH+ACC_GUARD-1:0] job_sum_o,
  output job_ctrl_t                             job_ctrl_o
);

  localparam int W     = 2 * SIDE_POINTS + 1;
  localparam int TW    = $clog2(W);
  localparam int CNT_W = $clog2(W + 1);
  localparam int AW    = SAMPLE_WIDTH + ACC_GUARD;

  front_state_e state_q, state_d;
  logic signed [SAMPLE_WIDTH-1:0] win_q [W];
  logic signed [SAMPLE_WIDTH-1:0] win_d [W];
  logic [CNT_W-1:0] seen_q, seen_d, pend_q, pend_d, seen_inc, pend_inc;
  logic [2:0] j_q, j_d, nf_q, nf_d, nb_q, nb_d;
  logic end_q, end_d, flush_q, flush_d;
  logic [TW-1:0] tap_q, tap_d;
  logic signed [AW-1:0] acc_q, acc_d, prod;
  logic signed [COEF_W-1:0] coef;
  logic accept, shift_en, clear_en;
  logic signed [SAMPLE_WIDTH-1:0] shift_val;

  function automatic logic [2:0] nb_of(input logic [CNT_W-1:0] seen, input logic [2:0] j);
    logic [CNT_W-1:0] avail;
    avail = seen - CNT_W'(1) - CNT_W'(j);
    return (avail > CNT_W'(SIDE_POINTS)) ? 3'(SIDE_POINTS) : 3'(avail);
  endfunction

  assign full_o      = (state_q != F_IDLE);
  assign accept      = push_i && !full_o;
  assign seen_inc    = (seen_q < CNT_W'(W)) ? seen_q + CNT_W'(1) : seen_q;
  assign pend_inc    = pend_q + CNT_W'(1);
  assign coef        = stencil_coef(nf_q, nb_q, 5'(tap_q) - 5'(SIDE_POINTS));
  assign prod        = AW'(coef) * AW'(win_q[tap_q]);
  assign job_valid_o = (state_q == F_PUSH);
  assign job_sum_o   = acc_q;
  assign job_ctrl_o  = '{den: stencil_den(nf_q, nb_q), eor: end_q};

  always_comb begin
    state_d   = state_q;
    seen_d    = seen_q;
    pend_d    = pend_q;
    j_d       = j_q;
    nf_d      = nf_q;
    nb_d      = nb_q;
    end_d     = end_q;
    flush_d   = flush_q;
    tap_d     = tap_q;
    acc_d     = acc_q;
    shift_en  = 1'b0;
    clear_en  = 1'b0;
    shift_val = sample_i;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          shift_en = 1'b1;
          seen_d   = seen_inc;
          pend_d   = pend_inc;
          if (last_i) begin
            flush_d = 1'b1;
            j_d     = 3'(SIDE_POINTS);
            state_d = F_SEL;
          end else if (pend_inc > CNT_W'(SIDE_POINTS)) begin
            nf_d    = 3'(SIDE_POINTS);
            nb_d    = nb_of(seen_inc, 3'(SIDE_POINTS));
            end_d   = 1'b0;
            pend_d  = pend_inc - CNT_W'(1);
            tap_d   = '0;
            acc_d   = '0;
            state_d = F_MAC;
          end
        end
      end
      F_SEL: begin
        if (CNT_W'(j_q) < pend_q) begin
          nf_d    = j_q;
          nb_d    = nb_of(seen_q, j_q);
          end_d   = (j_q == 3'd0);
          tap_d   = '0;
          acc_d   = '0;
          state_d = F_MAC;
        end else begin
          // slide the next pending sample onto the centre tap
          shift_en  = 1'b1;
          shift_val = '0;
          j_d       = j_q - 3'd1;
        end
      end
      F_MAC: begin
        acc_d = acc_q + prod;
        tap_d = tap_q + TW'(1);
        if (tap_q == TW'(W - 1)) state_d = F_PUSH;
      end
      F_PUSH: begin
        if (job_ready_i) begin
          if (!flush_q) begin
            state_d = F_IDLE;
          end else if (j_q == 3'd0) begin
            clear_en = 1'b1;
            seen_d   = '0;
            pend_d   = '0;
            flush_d  = 1'b0;
            state_d  = F_IDLE;
          end else begin
            shift_en  = 1'b1;
            shift_val = '0;
            j_d       = j_q - 3'd1;
            state_d   = F_SEL;
          end
        end
      end
      default: state_d = F_IDLE;
    endcase

    for (int i = 0; i < W; i++) win_d[i] = win_q[i];
    if (clear_en) begin
      for (int i = 0; i < W; i++) win_d[i] = '0;
    end else if (shift_en) begin
      for (int i = 0; i < W - 1; i++) win_d[i] = win_q[i + 1];
      win_d[W-1] = shift_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      for (int i = 0; i < W; i++) win_q[i] <= '0;
      seen_q  <= '0;
      pend_q  <= '0;
      j_q     <= '0;
      nf_q    <= '0;
      nb_q    <= '0;
      end_q   <= 1'b0;
      flush_q <= 1'b0;
      tap_q   <= '0;
      acc_q   <= '0;
    end else begin
      state_q <= state_d;
      for (int i = 0; i < W; i++) win_q[i] <= win_d[i];
      seen_q  <= seen_d;
      pend_q  <= pend_d;
      j_q     <= j_d;
      nf_q    <= nf_d;
      nb_q    <= nb_d;
      end_q   <= end_d;
      flush_q <= flush_d;
      tap_q   <= tap_d;
      acc_q   <= acc_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_tap_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == F_MAC) |-> (tap_q < TW'(W - 1)) || (tap_q == TW'(W - 1)))
    else $error("tap index beyond window");
  a_pend_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q <= seen_q))
    else $error("more pending results than samples seen");
`endif

endmodule

[rtl/core/fdd_queue.sv]
// ----------------------------------------------------------------------------
// fdd_queue: short job queue between front and back
// Two-entry register queue; either side stalls on its own.
// ----------------------------------------------------------------------------
module fdd_queue import fdd_pkg::*; #(
  parameter int DW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [DW-1:0] data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic [DW-1:0] data_o,
  output logic          empty_o
);

  localparam int PW = $clog2(JOB_QUEUE_DEPTH);
  localparam int CW = $clog2(JOB_QUEUE_DEPTH + 1);

  logic [DW-1:0] mem_q [JOB_QUEUE_DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = (cnt_q == CW'(JOB_QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= (wr_q == PW'(JOB_QUEUE_DEPTH - 1)) ? '0 : wr_q + PW'(1);
      if (do_pop)  rd_q <= (rd_q == PW'(JOB_QUEUE_DEPTH - 1)) ? '0 : rd_q + PW'(1);
      cnt_q <= cnt_q + CW'(do_push) - CW'(do_pop);
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(JOB_QUEUE_DEPTH))
    else $error("job queue over capacity");
`endif

endmodule

[rtl/core/fdd_back.sv]
// ----------------------------------------------------------------------------
// fdd_back: scaling, rounding and saturation of stencil sums
// Multiplies the sum magnitude by the reciprocal step in 32-bit slices, divides
// by the stencil denominator times 2^16 a few quotient bits a cycle, rounds
// half away from zero and saturates into the output register.
// ----------------------------------------------------------------------------
module fdd_back import fdd_pkg::*; #(
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     job_valid_i,
  input  logic signed [SAMPLE_WIDTH+ACC_GUARD-1:0] job_sum_i,
  input  job_ctrl_t                                job_ctrl_i,
  output logic                                     job_pop_o,
  input  logic [31:0]                              inv_step_i,
  input  logic                                     pop_i,
  output logic                                     empty_o,
  output logic signed [SAMPLE_WIDTH-1:0]           derivative_o,
  output logic                                     end_of_run_o
);

  localparam int AW   = SAMPLE_WIDTH + ACC_GUARD;
  localparam int NCH  = (AW + 31) / 32;
  localparam int MPW  = NCH * 32;
  localparam int PW   = MPW + 32;
  localparam int QB   = ((SAMPLE_WIDTH + DIV_STEPS) / DIV_STEPS) * DIV_STEPS;
  localparam int HW   = PW - QB;
  localparam int EW   = DEN_W + FRAC_BITS;
  localparam int NDIV = QB / DIV_STEPS;
  localparam int CW   = $clog2(NDIV + 1);

  back_state_e state_q, state_d;
  logic neg_q, neg_d, jeor_q, jeor_d, ovf_q, ovf_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [MPW-1:0] mag_q, mag_d;
  logic [PW-1:0] prod_q, prod_d;
  logic [EW-1:0] rem_q, rem_d, e;
  logic [QB-1:0] lo_q, lo_d, quo_q, quo_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic out_valid_q, out_valid_d, out_eor_q, out_eor_d, load;
  logic [SAMPLE_WIDTH-1:0] deriv_q, deriv_d;
  logic [AW-1:0] sum_abs;
  logic [63:0] pp;
  logic [HW-1:0] hi;
  logic [EW:0] r2;
  logic rnd, sat;
  logic [QB:0] q1, lim, quo_f, res_w;
  logic [EW-1:0] r;
  logic [QB-1:0] l, q;

  assign e        = {den_q, {FRAC_BITS{1'b0}}};
  assign sum_abs  = job_sum_i[AW-1] ? AW'(-job_sum_i) : AW'(job_sum_i);
  assign pp       = 64'(mag_q[MPW-1 -: 32]) * 64'(inv_step_i);
  assign hi       = prod_q[PW-1:QB];
  assign rnd      = ({rem_q, 1'b0} >= {1'b0, e});
  assign q1       = {1'b0, quo_q} + (QB+1)'(rnd);
  assign lim      = ((QB+1)'(1) << (SAMPLE_WIDTH - 1)) - (QB+1)'(!neg_q);
  assign sat      = ovf_q || (q1 > lim);
  assign quo_f    = sat ? lim : q1;
  assign res_w    = neg_q ? (~quo_f + (QB+1)'(1)) : quo_f;
  assign empty_o  = !out_valid_q;
  assign derivative_o = deriv_q;
  assign end_of_run_o = out_eor_q;

  always_comb begin
    state_d   = state_q;
    neg_d     = neg_q;
    jeor_d    = jeor_q;
    ovf_d     = ovf_q;
    den_d     = den_q;
    mag_d     = mag_q;
    prod_d    = prod_q;
    rem_d     = rem_q;
    lo_d      = lo_q;
    quo_d     = quo_q;
    cnt_d     = cnt_q;
    job_pop_o = 1'b0;
    load      = 1'b0;
    r         = rem_q;
    l         = lo_q;
    q         = quo_q;
    r2        = '0;
    case (state_q)
      B_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          neg_d     = job_sum_i[AW-1];
          jeor_d    = job_ctrl_i.eor;
          den_d     = job_ctrl_i.den;
          mag_d     = MPW'(sum_abs);
          prod_d    = '0;
          cnt_d     = '0;
          state_d   = B_MUL;
        end
      end
      B_MUL: begin
        // top slice first: shift the partial sum up and add the next product
        prod_d = (prod_q << 32) + PW'(pp);
        mag_d  = mag_q << 32;
        cnt_d  = cnt_q + CW'(1);
        if (cnt_q == CW'(NCH - 1)) state_d = B_CHK;
      end
      B_CHK: begin
        ovf_d   = (hi >= HW'(e));
        rem_d   = hi[EW-1:0];
        lo_d    = prod_q[QB-1:0];
        quo_d   = '0;
        cnt_d   = '0;
        state_d = (hi >= HW'(e)) ? B_DONE : B_DIV;
      end
      B_DIV: begin
        for (int s = 0; s < DIV_STEPS; s++) begin
          r2 = {r, l[QB-1]};
          l  = l << 1;
          q  = q << 1;
          if (r2 >= {1'b0, e}) begin
            r    = EW'(r2 - {1'b0, e});
            q[0] = 1'b1;
          end else begin
            r = EW'(r2);
          end
        end
        rem_d = r;
        lo_d  = l;
        quo_d = q;
        cnt_d = cnt_q + CW'(1);
        if (cnt_q == CW'(NDIV - 1)) state_d = B_DONE;
      end
      B_DONE: begin
        // hold until the output register frees up
        if (!out_valid_q || pop_i) begin
          load    = 1'b1;
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    deriv_d     = deriv_q;
    out_eor_d   = out_eor_q;
    if (load) begin
      out_valid_d = 1'b1;
      deriv_d     = res_w[SAMPLE_WIDTH-1:0];
      out_eor_d   = jeor_q;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      neg_q       <= 1'b0;
      jeor_q      <= 1'b0;
      ovf_q       <= 1'b0;
      den_q       <= DEN_W'(1);
      mag_q       <= '0;
      prod_q      <= '0;
      rem_q       <= '0;
      lo_q        <= '0;
      quo_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      deriv_q     <= '0;
      out_eor_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      neg_q       <= neg_d;
      jeor_q      <= jeor_d;
      ovf_q       <= ovf_d;
      den_q       <= den_d;
      mag_q       <= mag_d;
      prod_q      <= prod_d;
      rem_q       <= rem_d;
      lo_q        <= lo_d;
      quo_q       <= quo_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      deriv_q     <= deriv_d;
      out_eor_q   <= out_eor_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_pop_needs_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop_o |-> job_valid_i)
    else $error("job taken from empty queue");
  a_div_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_DIV) |-> (cnt_q < CW'(NDIV)))
    else $error("divider ran past its last step");
`endif

endmodule

[rtl/core/finite_difference_derivative_top.sv]
// ----------------------------------------------------------------------------
// finite_difference_derivative_top: streaming finite-difference derivative
// Push signed samples of a run, the final one flagged last; pop one
// saturated derivative per sample, in sample order, end_of_run on the last.
// Input: push/full; a beat moves when push is high and full is low.
// Output: empty/pop; the oldest result shows while empty is low and moves
// when pop is high. The APB port holds inverse_step at address 0.
// Results lag the input by SIDE_POINTS samples; the flagged sample releases
// the remaining results, up to SIDE_POINTS+1. Each result passes the front
// tap sequencer (one stencil tap a cycle), then the back scaler (job pop,
// NCH 32-bit multiply slices, range check, four quotient bits a cycle,
// output load); front and back overlap across the two-entry job queue, so
// throughput is set by the slower of the two. Reset empties the window,
// the queue and the output register and sets inverse_step to 1.0. A stalled
// receiver holds the output register, then the queue fills and the front
// raises full.
// ----------------------------------------------------------------------------
module finite_difference_derivative_top import fdd_pkg::*; #(
  parameter int SIDE_POINTS  = 4,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  input  logic                           last_i,
  output logic                           empty,
  input  logic                           pop,
  output logic signed [SAMPLE_WIDTH-1:0] derivative_o,
  output logic                           end_of_run_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int AW = SAMPLE_WIDTH + ACC_GUARD;
  localparam int DW = $bits(job_ctrl_t) + AW;

  logic [31:0] inv_step_q;
  logic job_valid, job_full, job_empty, job_pop;
  logic signed [AW-1:0] job_sum;
  job_ctrl_t job_ctrl, q_ctrl;
  logic [DW-1:0] q_out;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_INV_STEP) ? inv_step_q : 32'h0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_step_q <= INV_STEP_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_INV_STEP) begin
      inv_step_q <= pwdata;
    end
  end

  fdd_front #(
    .SIDE_POINTS (SIDE_POINTS),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .sample_i   (sample_i),
    .last_i     (last_i),
    .full_o     (full),
    .job_valid_o(job_valid),
    .job_ready_i(!job_full),
    .job_sum_o  (job_sum),
    .job_ctrl_o (job_ctrl)
  );

  fdd_queue #(
    .DW(DW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_valid),
    .data_i ({job_ctrl, job_sum}),
    .full_o (job_full),
    .pop_i  (job_pop),
    .data_o (q_out),
    .empty_o(job_empty)
  );

  assign q_ctrl = q_out[DW-1:AW];

  fdd_back #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (!job_empty),
    .job_sum_i   (q_out[AW-1:0]),
    .job_ctrl_i  (q_ctrl),
    .job_pop_o   (job_pop),
    .inv_step_i  (inv_step_q),
    .pop_i       (pop),
    .empty_o     (empty),
    .derivative_o(derivative_o),
    .end_of_run_o(end_of_run_o)
  );

endmodule

[dv/fdd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fdd_checker: derivative predictor and result scoreboard
// Watches the sample, result and register channels of the derivative block,
// predicts every derivative from its own copy of the window and compares
// each popped result with the oldest prediction.
// ----------------------------------------------------------------------------
module fdd_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic [31:0] sample_i,
  input  logic        last_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [31:0] derivative_o,
  input  logic        end_of_run_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count_o,
  output int          awaited_o
);
  import fdd_pkg::*;

  typedef struct packed {
    logic [31:0] deriv;
    logic        eor;
  } deriv_t;

  localparam int WIN = 9;
  localparam int SIDE = 4;

  localparam longint CEN_W [4][4] = '{
    '{1, 0, 0, 0}, '{8, -1, 0, 0}, '{45, -9, 1, 0}, '{672, -168, 32, -3}};
  localparam longint CEN_D [4] = '{2, 12, 60, 840};
  localparam longint ONE_W [4][5] = '{
    '{-1, 1, 0, 0, 0}, '{-3, 4, -1, 0, 0}, '{-11, 18, -9, 2, 0},
    '{-25, 48, -36, 16, -3}};
  localparam longint ONE_D [4] = '{1, 2, 6, 12};

  logic [31:0] inv_step;
  longint      window [WIN];
  int          seen;
  int          owed;
  deriv_t      awaited_q [$];
  int          fails;

  assign fail_count_o = fails;
  assign awaited_o    = awaited_q.size();

  // exact S * inv / (den * 2^16), round half away from zero, saturate
  function automatic logic [31:0] scale_sum(longint s, longint den);
    logic [127:0] mag, prod, e, q, r, lim;
    bit neg;
    neg  = s < 0;
    mag  = neg ? 128'(-s) : 128'(s);
    prod = mag * {96'b0, inv_step};
    e    = 128'(den) << 16;
    q    = prod / e;
    r    = prod % e;
    if (2 * r >= e) q = q + 1;
    lim = neg ? 128'h8000_0000 : 128'h7fff_ffff;
    if (q > lim) q = lim;
    return neg ? 32'(-q) : 32'(q);
  endfunction

  function automatic logic [31:0] slope_at(int idx, int nf, int nb);
    longint s;
    s = 0;
    if (nf == nb) begin
      if (nf == 0) return '0;
      for (int i = 1; i <= nf; i++)
        s += CEN_W[nf-1][i-1] * (window[idx+i] - window[idx-i]);
      return scale_sum(s, CEN_D[nf-1]);
    end
    if (nf > nb) begin
      s = ONE_W[nf-1][0] * window[idx];
      for (int i = 1; i <= nf; i++) s += ONE_W[nf-1][i] * window[idx+i];
      return scale_sum(s, ONE_D[nf-1]);
    end
    s = ONE_W[nb-1][0] * window[idx];
    for (int i = 1; i <= nb; i++) s += ONE_W[nb-1][i] * window[idx-i];
    return scale_sum(-s, ONE_D[nb-1]);
  endfunction

  function automatic int min_of(int a, int b);
    return a < b ? a : b;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    deriv_t exp_r;
    int j;
    if (!rst_ni) begin
      inv_step = INV_STEP_RESET;
      foreach (window[k]) window[k] = 0;
      seen  = 0;
      owed  = 0;
      fails = 0;
      awaited_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_INV_STEP)
        inv_step = pwdata;
      if (push && !full) begin
        for (int k = 0; k < WIN - 1; k++) window[k] = window[k+1];
        window[WIN-1] = longint'($signed(sample_i));
        if (seen < WIN) seen++;
        owed++;
        if (!last_i) begin
          if (owed > SIDE) begin
            exp_r.deriv = slope_at(SIDE, SIDE, min_of(SIDE, seen - 1 - SIDE));
            exp_r.eor   = 1'b0;
            awaited_q.insert(awaited_q.size(), exp_r);
            owed--;
          end
        end else begin
          // flush every owed sample, oldest first
          for (int i = owed; i > 0; i--) begin
            j = i - 1;
            exp_r.deriv = slope_at(WIN - 1 - j, j, min_of(SIDE, seen - 1 - j));
            exp_r.eor   = (j == 0);
            awaited_q.insert(awaited_q.size(), exp_r);
          end
          foreach (window[k]) window[k] = 0;
          seen = 0;
          owed = 0;
        end
      end
      if (pop && !empty) begin
        if (awaited_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected result %h eor %b", $realtime, derivative_o,
                     end_of_run_o);
        end else begin
          exp_r = awaited_q.pop_front();
          if (exp_r.deriv !== derivative_o || exp_r.eor !== end_of_run_o) begin
            fails++;
            if (fails <= 10)
              $display("%0t: derivative exp %h eor %b, got %h eor %b", $realtime,
                       exp_r.deriv, exp_r.eor, derivative_o, end_of_run_o);
          end
        end
      end
    end
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: derivative block testbench
// Streams directed and random sample runs through the block under several
// step settings and idling mixes; the checker predicts and scores results.
// ----------------------------------------------------------------------------
module tb;
  import fdd_pkg::*;

  localparam logic [2:0] INV_STEP_ADDR = 3'(4 * REG_INV_STEP);
  localparam int CYCLE_LIMIT = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0, pop = 1'b0, last_i = 1'b0;
  logic [31:0] sample_i = '0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic        full, empty, end_of_run_o, pready;
  logic [31:0] derivative_o, prdata;
  int          fail_count, awaited, cycles;
  int          send_idle_pct, recv_idle_pct;
  logic [31:0] prev_sample;

  always #6 clk_i = ~clk_i;

  finite_difference_derivative_top uut (.*);

  fdd_checker chk (.fail_count_o(fail_count), .awaited_o(awaited), .*);

  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= recv_idle_pct);
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  task automatic send_sample(input logic [31:0] s, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push     <= 1'b1;
    sample_i <= s;
    last_i   <= l;
    @(negedge clk_i);
    while (full) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // sample the outstanding count away from the active edge
  task automatic wait_results();
    @(negedge clk_i);
    while (awaited != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic drain();
    push <= 1'b0;
    wait_results();
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_step(input logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= INV_STEP_ADDR;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [31:0] pick_sample();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      2: return 32'($signed($urandom_range(2000)) - 1000);
      default: return prev_sample + 32'($signed($urandom_range(8192)) - 4096);
    endcase
  endfunction

  task automatic random_run(input int len, input bit hold_off);
    for (int i = 0; i < len; i++) begin
      prev_sample = pick_sample();
      send_sample(prev_sample, i == len - 1);
      if (hold_off && i == len / 2) begin
        push <= 1'b0;
        wait_results();
      end
    end
  endtask

  initial begin
    int sent;
    int len;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    prev_sample   = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // isolated sample, short runs, extremes at unit step
    send_sample(32'h7fff_ffff, 1'b1);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h7fff_ffff, 1'b1);
    for (int i = 0; i < 3; i++) send_sample(32'(i * 65536), i == 2);
    for (int i = 0; i < 9; i++)
      send_sample(i[0] ? 32'h8000_0000 : 32'h7fff_ffff, i == 8);
    drain();
    write_step('0);
    for (int i = 0; i < 5; i++) send_sample($urandom, i == 4);
    drain();
    write_step(32'hffff_ffff);
    for (int i = 0; i < 5; i++) send_sample(32'(i * i * 4096), i == 4);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 69 : 0;
      recv_idle_pct = (phase == 0) ? 69 : (phase == 1) ? 13 : 0;
      write_step(phase == 2 ? 32'h0001_0000 : $urandom);
      sent = 0;
      while (sent < 100) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 20);
        random_run(len, phase == 1 && sent == 0);
        sent += len;
      end
      drain();
    end

    if (fail_count == 0 && awaited == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
